// ----- rtl/lfo_pkg.sv -----
// lfo_pkg: shared constants, types and the sine table of the lfo waveform generator
package lfo_pkg;

  // angle resolution and sine fraction of the quarter-wave table
  localparam int ANGLE_BITS         = 10;
  localparam int SINE_FRACTION_BITS = 15;
  localparam int QUARTER            = 1 << (ANGLE_BITS - 2);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // phase modulo: 33-bit sum, four restoring steps per stage
  localparam int SUM_W      = 33;
  localparam int MOD_PER    = 4;
  localparam int MOD_STAGES = (SUM_W + MOD_PER - 1) / MOD_PER;
  localparam int MOD_W      = MOD_STAGES * MOD_PER;

  // shared level/angle divider: two quotient bits per stage
  localparam int DIV_Q      = ANGLE_BITS + 2;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = (DIV_Q + DIV_PER - 1) / DIV_PER;
  localparam int DIV_QW     = DIV_STAGES * DIV_PER;
  localparam int DIV_NW     = 16 + DIV_QW;

  // sine mix arithmetic
  localparam int TERM_W = SINE_FRACTION_BITS + 2;
  localparam int NUM_W  = SINE_FRACTION_BITS + 12;

  // register indexes of the write port
  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_PHASE   = 3'd1,
    REG_WAVE    = 3'd2,
    REG_MID     = 3'd3,
    REG_FLOOR   = 3'd4,
    REG_CEILING = 3'd5
  } reg_index_t;

  // wave select codes, anything else acts as square
  localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
  localparam logic [1:0] WAVE_SINE     = 2'd1;

  // what the back end does with a beat
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_TRI,
    KIND_SINE
  } kind_t;

  typedef logic [SINE_FRACTION_BITS:0] rom_t [QUARTER+1];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine in Q(SINE_FRACTION_BITS), Taylor series in Q30
  function automatic rom_t build_rom();
    rom_t             rom;
    longint unsigned  theta;
    longint unsigned  th2;
    longint unsigned  term;
    longint unsigned  v;
    longint           sum;
    longint unsigned  one;
    one = 64'd1 << SINE_FRACTION_BITS;
    for (int k = 0; k <= QUARTER; k++) begin
      theta = (HALF_PI_Q30 * longint'(k) + (QUARTER >> 1)) >> (ANGLE_BITS - 2);
      th2   = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int n = 1; n <= 10; n++) begin
        term = div_u64((term * th2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = ((longint'(sum) << SINE_FRACTION_BITS) + (64'd1 << 29)) >> 30;
      if (v > one) v = one;
      rom[k] = v[SINE_FRACTION_BITS:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

// ----- rtl/lfo_if.sv -----
// lfo_if: valid/ready channels for tick beats and level beats
interface lfo_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_count;
  modport source (output valid, output tick_count, input ready);
  modport sink (input valid, input tick_count, output ready);
endinterface

interface lfo_level_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

// ----- rtl/lfo_waveform_generator.sv -----
// lfo_waveform_generator: pipelined low-frequency oscillator, one level per tick beat
//
// Takes one tick beat per cycle while the output is not stalled and returns one
// 8-bit level per beat, in order. The phase modulo is a 9-stage restoring remainder
// (four bits a stage); triangle levels and sine angles share one 6-stage divider
// (two quotient bits a stage), followed by a sine table stage, a mix multiplier
// stage and the output register. Any stall on the output freezes the whole
// pipeline, so tick_in.ready drops in the same cycle.
// Registers: 0 period, 1 phase offset, 2 wave select, 3 mid point, 4 floor, 5 ceiling;
// write them only while no beat is in flight.
module lfo_waveform_generator (
  input  logic        clk,
  input  logic        rst,
  lfo_tick_if.sink    tick_in,
  lfo_level_if.source level_out,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);
  import lfo_pkg::*;

  // configuration registers
  logic [15:0] period_ticks;
  logic [15:0] phase_offset;
  logic [1:0]  wave_select;
  logic [15:0] mid_point;
  logic [7:0]  floor_level;
  logic [7:0]  ceiling_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks  <= 16'd1000;
      phase_offset  <= 16'd0;
      wave_select   <= 2'd2;
      mid_point     <= 16'd500;
      floor_level   <= 8'd0;
      ceiling_level <= 8'd255;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_PERIOD:  period_ticks  <= wr_data;
        REG_PHASE:   phase_offset  <= wr_data;
        REG_WAVE:    wave_select   <= wr_data[1:0];
        REG_MID:     mid_point     <= wr_data;
        REG_FLOOR:   floor_level   <= wr_data[7:0];
        REG_CEILING: ceiling_level <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // derived configuration
  logic [15:0]       p_eff;
  logic signed [8:0] span_d;
  assign p_eff  = (period_ticks == 16'd0) ? 16'd1 : period_ticks;
  assign span_d = $signed({1'b0, ceiling_level}) - $signed({1'b0, floor_level});

  // global advance: output register empty or being taken
  logic en;
  logic o_valid;
  assign en            = !o_valid || level_out.ready;
  assign tick_in.ready = en;

  // phase modulo stages
  logic              m_valid [MOD_STAGES+1];
  logic [MOD_W-1:0]  m_num   [MOD_STAGES+1];
  logic [15:0]       m_rem   [MOD_STAGES+1];
  logic [15:0]       m_rem_next [MOD_STAGES];

  always_comb begin
    logic [16:0] r2;
    logic [15:0] r;
    for (int k = 0; k < MOD_STAGES; k++) begin
      r = m_rem[k];
      for (int j = 0; j < MOD_PER; j++) begin
        r2 = {r, m_num[k][MOD_W-1-k*MOD_PER-j]};
        if (r2 >= {1'b0, p_eff}) r2 = r2 - {1'b0, p_eff};
        r = r2[15:0];
      end
      m_rem_next[k] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MOD_STAGES; k++) m_valid[k] <= 1'b0;
    end else if (en) begin
      m_valid[0] <= tick_in.valid;
      for (int k = 0; k < MOD_STAGES; k++) m_valid[k+1] <= m_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num[0] <= MOD_W'({1'b0, tick_in.tick_count} + {17'd0, phase_offset});
      m_rem[0] <= 16'd0;
      for (int k = 0; k < MOD_STAGES; k++) begin
        m_num[k+1] <= m_num[k];
        m_rem[k+1] <= m_rem_next[k];
      end
    end
  end

  // shape setup: products for the triangle, direct levels for square and corner
  logic [15:0] x;
  assign x = m_rem[MOD_STAGES];

  logic               p1_valid;
  kind_t              p1_kind;
  logic [7:0]         p1_lvl;
  logic [15:0]        p1_x;
  logic [23:0]        p1_prod_a;
  logic signed [25:0] p1_prod_b;
  logic [15:0]        p1_den;

  kind_t              s1_kind;
  logic [7:0]         s1_lvl;
  logic [7:0]         s1_a;
  logic [15:0]        s1_b;
  logic signed [8:0]  s1_dd;
  logic signed [16:0] s1_t;

  always_comb begin
    s1_kind = KIND_DIRECT;
    s1_lvl  = (x >= mid_point) ? floor_level : ceiling_level;
    s1_a    = floor_level;
    s1_b    = mid_point;
    s1_dd   = span_d;
    s1_t    = $signed({1'b0, x});
    if (wave_select == WAVE_TRIANGLE) begin
      if (x <= mid_point) begin
        if (mid_point == 16'd0) begin
          s1_lvl = ceiling_level;
        end else begin
          s1_kind = KIND_TRI;
        end
      end else begin
        s1_kind = KIND_TRI;
        s1_a    = ceiling_level;
        s1_b    = p_eff - mid_point;
        s1_dd   = -span_d;
        s1_t    = $signed({1'b0, x - mid_point});
      end
    end else if (wave_select == WAVE_SINE) begin
      s1_kind = KIND_SINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else if (en) p1_valid <= m_valid[MOD_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_kind   <= s1_kind;
      p1_lvl    <= s1_lvl;
      p1_x      <= x;
      p1_prod_a <= s1_a * s1_b;
      p1_prod_b <= s1_dd * s1_t;
      p1_den    <= s1_b;
    end
  end

  // divider operands, then the restoring divider stages
  logic               d_valid [DIV_STAGES+1];
  kind_t              d_kind  [DIV_STAGES+1];
  logic [7:0]         d_lvl   [DIV_STAGES+1];
  logic [DIV_QW-1:0]  d_low   [DIV_STAGES+1];
  logic [16:0]        d_rem   [DIV_STAGES+1];
  logic [16:0]        d_den   [DIV_STAGES+1];
  logic [16:0]        d_rem_next [DIV_STAGES];
  logic [DIV_QW-1:0]  d_low_next [DIV_STAGES];

  logic signed [26:0] tri_num;
  logic [DIV_NW-1:0]  n_op;
  logic [16:0]        den_op;

  always_comb begin
    tri_num = $signed({3'b0, p1_prod_a}) + 27'(p1_prod_b);
    if (p1_kind == KIND_SINE) begin
      n_op   = (DIV_NW'(p1_x) << (ANGLE_BITS + 1)) + DIV_NW'(p_eff);
      den_op = {p_eff, 1'b0};
    end else begin
      n_op   = DIV_NW'({tri_num[25:0], 1'b0}) + DIV_NW'(p1_den);
      den_op = {p1_den, 1'b0};
    end
  end

  // quotient bits replace the consumed dividend bits at the bottom of d_low
  always_comb begin
    logic [17:0]       r2;
    logic [16:0]       r;
    logic [DIV_QW-1:0] lo;
    for (int k = 0; k < DIV_STAGES; k++) begin
      r  = d_rem[k];
      lo = d_low[k];
      for (int j = 0; j < DIV_PER; j++) begin
        r2 = {r, lo[DIV_QW-1]};
        lo = {lo[DIV_QW-2:0], 1'b0};
        if (r2 >= {1'b0, d_den[k]}) begin
          r2    = r2 - {1'b0, d_den[k]};
          lo[0] = 1'b1;
        end
        r = r2[16:0];
      end
      d_rem_next[k] = r;
      d_low_next[k] = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) d_valid[k] <= 1'b0;
    end else if (en) begin
      d_valid[0] <= p1_valid;
      for (int k = 0; k < DIV_STAGES; k++) d_valid[k+1] <= d_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_kind[0] <= p1_kind;
      d_lvl[0]  <= p1_lvl;
      d_low[0]  <= n_op[DIV_QW-1:0];
      d_rem[0]  <= {1'b0, n_op[DIV_NW-1:DIV_QW]};
      d_den[0]  <= den_op;
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_kind[k+1] <= d_kind[k];
        d_lvl[k+1]  <= d_lvl[k];
        d_low[k+1]  <= d_low_next[k];
        d_rem[k+1]  <= d_rem_next[k];
        d_den[k+1]  <= d_den[k];
      end
    end
  end

  // sine table stage: quadrant folding into 2^SFB + s
  logic [DIV_QW-1:0]     q;
  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] ridx;
  logic [ANGLE_BITS-2:0] fidx;
  logic [TERM_W-1:0]     rom_val;
  logic [TERM_W-1:0]     term_c;

  assign q    = d_low[DIV_STAGES];
  assign ang  = q[ANGLE_BITS-1:0];
  assign quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
  assign ridx = {1'b0, ang[ANGLE_BITS-3:0]};
  assign fidx = (ANGLE_BITS-1)'(QUARTER) - ridx;

  always_comb begin
    rom_val = TERM_W'(SINE_ROM[(quad[0]) ? fidx : ridx]);
    if (quad[1]) term_c = (TERM_W'(1) << SINE_FRACTION_BITS) - rom_val;
    else term_c = (TERM_W'(1) << SINE_FRACTION_BITS) + rom_val;
  end

  logic              r_valid;
  kind_t             r_kind;
  logic [7:0]        r_lvl;
  logic [TERM_W-1:0] r_term;

  always_ff @(posedge clk) begin
    if (rst) r_valid <= 1'b0;
    else if (en) r_valid <= d_valid[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_kind <= d_kind[DIV_STAGES];
      r_lvl  <= (d_kind[DIV_STAGES] == KIND_TRI) ? q[7:0] : d_lvl[DIV_STAGES];
      r_term <= term_c;
    end
  end

  // sine mix: floor scaled plus span times the folded sine
  logic              u_valid;
  logic              u_sine;
  logic [7:0]        u_lvl;
  logic signed [NUM_W-1:0] u_num;

  always_ff @(posedge clk) begin
    if (rst) u_valid <= 1'b0;
    else if (en) u_valid <= r_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_sine <= (r_kind == KIND_SINE);
      u_lvl  <= r_lvl;
      u_num  <= $signed(NUM_W'({floor_level, {(SINE_FRACTION_BITS+1){1'b0}}}))
              + NUM_W'(span_d * $signed({1'b0, r_term}));
    end
  end

  // output register with rounding of the sine mix
  logic [NUM_W-1:0] rounded;
  assign rounded = NUM_W'(u_num) + (NUM_W'(1) << SINE_FRACTION_BITS);

  logic [7:0] o_level;

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (en) o_valid <= u_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_level <= u_sine ? rounded[SINE_FRACTION_BITS+8:SINE_FRACTION_BITS+1] : u_lvl;
    end
  end

  assign level_out.valid = o_valid;
  assign level_out.level = o_level;

endmodule

// ----- rtl/lfo_checker.sv -----
// lfo_checker: port-level checks of the lfo waveform generator, bound to the top level
module lfo_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] level
);

  // a held level beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level))
    else $error("level beat dropped or changed while stalled");

  // a stalled output blocks new ticks
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("tick accepted while output stalled");

  // an empty output register never blocks input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("level beat right after reset");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tick_in.valid),
  .in_ready  (tick_in.ready),
  .out_valid (level_out.valid),
  .out_ready (level_out.ready),
  .level     (level_out.level)
);

// ----- verif/lfo_waveform_generator_test.sv -----
// lfo_waveform_generator_test: self-checking testbench for the lfo waveform generator
`timescale 1ns / 100ps

module lfo_waveform_generator_test;
  import lfo_pkg::*;

  localparam int LATENCY_WAIT = 30;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  lfo_tick_if  tick_ch ();
  lfo_level_if level_ch ();

  lfo_waveform_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .tick_in   (tick_ch),
    .level_out (level_ch),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  // local copy of the register file
  logic [15:0] cfg_period;
  logic [15:0] cfg_phase;
  logic [1:0]  cfg_wave;
  logic [15:0] cfg_mid;
  logic [7:0]  cfg_floor;
  logic [7:0]  cfg_ceiling;

  longint      sine_quarter [QUARTER+1];
  logic [7:0]  expected_levels [$];
  int          error_count;
  int          ticks_sent;
  int          levels_seen;
  int          settings_used;
  int          cycle_count;
  bit          send_burst;
  bit          recv_burst;

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d levels pending", cycle_count,
               expected_levels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // quarter-wave sine table, Taylor series in Q30
  function automatic void fill_sine_quarter();
    longint unsigned theta, th2, term, v;
    longint          sum;
    for (int k = 0; k <= QUARTER; k++) begin
      theta = (HALF_PI_Q30 * longint'(k) + longint'(QUARTER / 2)) / longint'(QUARTER);
      th2   = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = ((unsigned'(sum) << SINE_FRACTION_BITS) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << SINE_FRACTION_BITS)) v = 64'd1 << SINE_FRACTION_BITS;
      sine_quarter[k] = longint'(v);
    end
  endfunction

  // half-up rounded division of a clamped numerator
  function automatic longint div_round(longint num, longint den);
    if (num < 0) num = 0;
    return (num * 2 + den) / (den * 2);
  endfunction

  // expected level for one tick count under the current registers
  function automatic logic [7:0] predict_level(logic [31:0] tick);
    longint p, x, f, c, d, m, a, r, s, num, y;
    int     quad;
    p = (cfg_period == 16'd0) ? 1 : longint'(cfg_period);
    x = (longint'(tick) + longint'(cfg_phase)) % p;
    f = longint'(cfg_floor);
    c = longint'(cfg_ceiling);
    d = c - f;
    m = longint'(cfg_mid);
    if (cfg_wave == WAVE_TRIANGLE) begin
      if (x <= m) y = (m == 0) ? c : div_round(f * m + d * x, m);
      else y = div_round(c * (p - m) - d * (x - m), p - m);
    end else if (cfg_wave == WAVE_SINE) begin
      a = (((x << (ANGLE_BITS + 1)) + p) / (2 * p)) & ((64'd1 << ANGLE_BITS) - 1);
      quad = int'(a >> (ANGLE_BITS - 2));
      r = a & longint'(QUARTER - 1);
      case (quad)
        0: s = sine_quarter[r];
        1: s = sine_quarter[QUARTER - r];
        2: s = -sine_quarter[r];
        default: s = -sine_quarter[QUARTER - r];
      endcase
      num = f * (64'd1 << (SINE_FRACTION_BITS + 1)) + d * ((64'd1 << SINE_FRACTION_BITS) + s);
      if (num < 0) num = 0;
      y = (num + (64'd1 << SINE_FRACTION_BITS)) >> (SINE_FRACTION_BITS + 1);
    end else begin
      y = (x >= m) ? f : c;
    end
    return y[7:0];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // compare each level beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && level_ch.valid && level_ch.ready) begin
      levels_seen++;
      if (expected_levels.size() == 0) report_mismatch("unexpected level", level_ch.level, 8'd0);
      else begin
        if (level_ch.level !== expected_levels[0])
          report_mismatch("level", level_ch.level, expected_levels[0]);
        void'(expected_levels.pop_front());
      end
    end
  end

  // level sink with random stalls
  initial begin
    int n;
    level_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = recv_burst ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        level_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      level_ch.ready <= 1'b1;
      do @(posedge clk); while (!(level_ch.valid && level_ch.ready));
      @(negedge clk);
    end
  end

  // send one tick beat; called and returns at a falling edge
  task automatic send_tick(logic [31:0] tick);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.tick_count <= tick;
    do @(posedge clk); while (!tick_ch.ready);
    expected_levels.push_back(predict_level(tick));
    ticks_sent++;
    @(negedge clk);
  endtask

  // wait until every level has come and the pipeline is empty
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PERIOD:  cfg_period  = data;
      REG_PHASE:   cfg_phase   = data;
      REG_WAVE:    cfg_wave    = data[1:0];
      REG_MID:     cfg_mid     = data;
      REG_FLOOR:   cfg_floor   = data[7:0];
      REG_CEILING: cfg_ceiling = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(logic [15:0] period, logic [15:0] phase, logic [1:0] wave,
                         logic [15:0] mid, logic [7:0] lo, logic [7:0] hi);
    drain();
    write_reg(REG_PERIOD, period);
    write_reg(REG_PHASE, phase);
    write_reg(REG_WAVE, {14'd0, wave});
    write_reg(REG_MID, mid);
    write_reg(REG_FLOOR, {8'd0, lo});
    write_reg(REG_CEILING, {8'd0, hi});
    settings_used++;
  endtask

  // reset values: square, period 1000, edge at 500
  task automatic test_reset_defaults();
    send_tick(32'd0);
    send_tick(32'd499);
    send_tick(32'd500);
    send_tick(32'd999);
    send_tick(32'd1000);
    send_tick(32'hFFFF_FFFF);
  endtask

  // shapes at their corners and the open cases
  task automatic test_directed_shapes();
    // triangle peak at zero
    set_all(16'd100, 16'd0, WAVE_TRIANGLE, 16'd0, 8'd10, 8'd200);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd99);
    // triangle, inverted levels, full offset
    set_all(16'd65535, 16'hFFFF, WAVE_TRIANGLE, 16'd30000, 8'd255, 8'd0);
    send_tick(32'd0);
    send_tick(32'd30000);
    send_tick(32'hFFFF_FFFF);
    // mid point beyond period, rising only
    set_all(16'd50, 16'd7, WAVE_TRIANGLE, 16'd65535, 8'd0, 8'd255);
    send_tick(32'd42);
    send_tick(32'd49);
    // sine at quadrant points
    set_all(16'd1024, 16'd0, WAVE_SINE, 16'd0, 8'd0, 8'd255);
    send_tick(32'd0);
    send_tick(32'd256);
    send_tick(32'd512);
    send_tick(32'd768);
    send_tick(32'd1023);
    // zero period, select three, square beyond period
    set_all(16'd0, 16'd123, 2'd3, 16'd65535, 8'd3, 8'd250);
    send_tick(32'd77);
    send_tick(32'hFFFF_FFFF);
    set_all(16'd1, 16'd0, WAVE_SINE, 16'd1, 8'd255, 8'd0);
    send_tick(32'd5);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random settings, random and sequential ticks
  task automatic test_random_ticks();
    logic [15:0] period, mid;
    logic [31:0] tick;
    for (int phase_no = 0; phase_no < 10; phase_no++) begin
      case ($urandom_range(0, 5))
        0: period = 16'd0;
        1: period = 16'd65535;
        2: period = 16'($urandom_range(1, 8));
        3: period = 16'($urandom_range(1, 65535));
        default: period = 16'($urandom_range(2, 2000));
      endcase
      case ($urandom_range(0, 4))
        0: mid = 16'd0;
        1: mid = period;
        2: mid = 16'($urandom_range(0, 65535));
        default: mid = (period == 0) ? 16'd0 : 16'($urandom_range(0, period));
      endcase
      set_all(period, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), mid,
              pick_level(), pick_level());
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      tick = $urandom();
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 3))
          0: tick = tick + 1;
          1: tick = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
          default: tick = $urandom();
        endcase
        send_tick(tick);
        // hold off until the pipeline has emptied
        if (i == 25 && phase_no == 4) begin
          tick_ch.valid <= 1'b0;
          while (expected_levels.size() != 0) @(negedge clk);
        end
      end
      send_burst = 1'b0;
      recv_burst = 1'b0;
    end
  endtask

  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = REG_PERIOD;
    wr_data            = 16'd0;
    tick_ch.valid      = 1'b0;
    tick_ch.tick_count = 32'd0;
    cycle_count        = 0;
    error_count        = 0;
    ticks_sent         = 0;
    levels_seen        = 0;
    settings_used      = 0;
    send_burst         = 1'b0;
    recv_burst         = 1'b0;
    cfg_period         = 16'd1000;
    cfg_phase          = 16'd0;
    cfg_wave           = 2'd2;
    cfg_mid            = 16'd500;
    cfg_floor          = 8'd0;
    cfg_ceiling        = 8'd255;
    fill_sine_quarter();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_directed_shapes();
    test_random_ticks();
    drain();

    $display("sent %0d tick beats and checked %0d level beats", ticks_sent, levels_seen);
    $display("covered %0d register settings over all shapes and edge cases", settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
